// File: sv/erll_pkg.sv
// Shared types and constants for the extent run list lookup unit.
package erll_pkg;

    localparam int VCN_W   = 64;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 4;
    localparam int LANES   = VCN_W / BYTE_W;

    localparam logic [CNT_W-1:0] NIBBLE_MASK = 4'hf;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_LENGTH = 4'b0100,
        PH_DELTA  = 4'b1000
    } phase_t;

endpackage

// File: sv/extent_run_list_lookup_unit.sv
// Extent run list lookup: decodes a run list word by word and locates a target cluster.
// Throughput: one input word per cycle, held while a result word waits on m_ready; the
// per-word decode, the run accumulate and the hit test sit between the input register and
// the result register, and only a word that ends a lookup loads the result on the m_ side.
// Reset: synchronous, active low; the unit returns to idle and waits for a start word,
// and no result word is pending.
module extent_run_list_lookup_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_list_start,
    input  logic [erll_pkg::BYTE_W-1:0] s_run_byte,
    input  logic [erll_pkg::VCN_W-1:0]  s_target_vcn,
    input  logic [erll_pkg::VCN_W-1:0]  s_low_vcn,
    input  logic [erll_pkg::VCN_W-1:0]  s_high_vcn,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic [erll_pkg::VCN_W-1:0]  m_physical_cluster,
    output logic [erll_pkg::VCN_W-1:0]  m_clusters_left
);
    import erll_pkg::*;

    logic               in_valid_reg;
    logic               in_start_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic [VCN_W-1:0]   in_target_reg;
    logic [VCN_W-1:0]   in_low_reg;
    logic [VCN_W-1:0]   in_high_reg;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   length_bytes_reg, length_bytes_next;
    logic [CNT_W-1:0]   delta_bytes_reg, delta_bytes_next;
    logic [CNT_W-1:0]   byte_pos_reg, byte_pos_next;
    logic [VCN_W-1:0]   run_length_reg, run_length_next;
    logic [VCN_W-1:0]   delta_acc_reg, delta_acc_next;
    logic [VCN_W-1:0]   cluster_sum_reg, cluster_sum_next;
    logic [VCN_W-1:0]   base_vcn_reg, base_vcn_next;
    logic [VCN_W-1:0]   wanted_vcn_reg, wanted_vcn_next;
    logic [VCN_W-1:0]   offset_reg, offset_next;
    logic               base_le_reg, base_le_next;

    logic               m_valid_reg;
    logic               m_found_reg, m_found_next;
    logic [VCN_W-1:0]   m_lcn_reg, m_lcn_next;
    logic [VCN_W-1:0]   m_left_reg, m_left_next;

    logic               go;
    logic               emit;
    logic               finish;
    logic               do_header;
    logic [VCN_W-1:0]   len_full;
    logic [VCN_W-1:0]   delta_full;
    logic [CNT_W-1:0]   pos_inc;
    logic [CNT_W-1:0]   hdr_len;
    logic [CNT_W-1:0]   hdr_delta;

    assign go      = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || go;

    assign pos_inc   = byte_pos_reg + CNT_W'(1);
    assign hdr_len   = in_byte_reg[CNT_W-1:0] & NIBBLE_MASK;
    assign hdr_delta = in_byte_reg[BYTE_W-1:CNT_W] & NIBBLE_MASK;

    always_comb begin
        len_full   = run_length_reg;
        delta_full = delta_acc_reg;
        for (int i = 0; i < LANES; i++) begin
            if (phase_reg == PH_LENGTH && byte_pos_reg == CNT_W'(i)) begin
                len_full[BYTE_W*i +: BYTE_W] = in_byte_reg;
            end
            if (phase_reg == PH_DELTA && byte_pos_reg == CNT_W'(i)) begin
                delta_full[BYTE_W*i +: BYTE_W] = in_byte_reg;
            end
        end
        if (phase_reg == PH_DELTA && pos_inc >= delta_bytes_reg &&
            delta_bytes_reg < CNT_W'(LANES) && in_byte_reg[BYTE_W-1]) begin
            for (int i = 0; i < LANES; i++) begin
                if (CNT_W'(i) >= delta_bytes_reg) begin
                    delta_full[BYTE_W*i +: BYTE_W] = '1;
                end
            end
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        length_bytes_next = length_bytes_reg;
        delta_bytes_next  = delta_bytes_reg;
        byte_pos_next     = byte_pos_reg;
        run_length_next   = run_length_reg;
        delta_acc_next    = delta_acc_reg;
        cluster_sum_next  = cluster_sum_reg;
        base_vcn_next     = base_vcn_reg;
        wanted_vcn_next   = wanted_vcn_reg;
        offset_next       = wanted_vcn_reg - base_vcn_reg;
        base_le_next      = base_vcn_reg <= wanted_vcn_reg;
        emit              = 1'b0;
        finish            = 1'b0;
        do_header         = 1'b0;
        m_found_next      = 1'b0;
        m_lcn_next        = '0;
        m_left_next       = '0;

        if (go) begin
            if (in_start_reg) begin
                wanted_vcn_next  = in_target_reg;
                cluster_sum_next = '0;
                base_vcn_next    = in_low_reg;
                offset_next      = in_target_reg - in_low_reg;
                base_le_next     = 1'b1;
                if (in_target_reg < in_low_reg || in_target_reg > in_high_reg) begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    do_header = 1'b1;
                end
            end else begin
                unique case (phase_reg)
                    PH_IDLE: begin
                    end
                    PH_HEADER: begin
                        do_header = 1'b1;
                    end
                    PH_LENGTH: begin
                        run_length_next = len_full;
                        byte_pos_next   = pos_inc;
                        if (pos_inc >= length_bytes_reg) begin
                            byte_pos_next = '0;
                            if (delta_bytes_reg != '0) begin
                                phase_next = PH_DELTA;
                            end else begin
                                finish = 1'b1;
                            end
                        end
                    end
                    PH_DELTA: begin
                        delta_acc_next = delta_full;
                        byte_pos_next  = pos_inc;
                        if (pos_inc >= delta_bytes_reg) begin
                            byte_pos_next = '0;
                            finish        = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // A nonzero header always has at least one length or delta byte to follow.
            if (do_header) begin
                if (in_byte_reg == '0) begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    length_bytes_next = hdr_len;
                    delta_bytes_next  = hdr_delta;
                    byte_pos_next     = '0;
                    run_length_next   = '0;
                    delta_acc_next    = '0;
                    phase_next        = (hdr_len != '0) ? PH_LENGTH : PH_DELTA;
                end
            end

            if (finish) begin
                cluster_sum_next = cluster_sum_reg + delta_full;
                if (base_le_reg && offset_reg < len_full) begin
                    emit         = 1'b1;
                    phase_next   = PH_IDLE;
                    m_found_next = 1'b1;
                    m_lcn_next   = (delta_full == '0) ? '0 :
                                   cluster_sum_reg + delta_full + offset_reg;
                    m_left_next  = len_full - offset_reg;
                end else begin
                    base_vcn_next = base_vcn_reg + len_full;
                    phase_next    = PH_HEADER;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            phase_reg        <= PH_IDLE;
            length_bytes_reg <= '0;
            delta_bytes_reg  <= '0;
            byte_pos_reg     <= '0;
            run_length_reg   <= '0;
            delta_acc_reg    <= '0;
            cluster_sum_reg  <= '0;
            base_vcn_reg     <= '0;
            wanted_vcn_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            phase_reg        <= phase_next;
            length_bytes_reg <= length_bytes_next;
            delta_bytes_reg  <= delta_bytes_next;
            byte_pos_reg     <= byte_pos_next;
            run_length_reg   <= run_length_next;
            delta_acc_reg    <= delta_acc_next;
            cluster_sum_reg  <= cluster_sum_next;
            base_vcn_reg     <= base_vcn_next;
            wanted_vcn_reg   <= wanted_vcn_next;
            if (go && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_start_reg  <= s_list_start;
            in_byte_reg   <= s_run_byte;
            in_target_reg <= s_target_vcn;
            in_low_reg    <= s_low_vcn;
            in_high_reg   <= s_high_vcn;
        end
        offset_reg  <= offset_next;
        base_le_reg <= base_le_next;
        if (go && emit) begin
            m_found_reg <= m_found_next;
            m_lcn_reg   <= m_lcn_next;
            m_left_reg  <= m_left_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_found            = m_found_reg;
    assign m_physical_cluster = m_lcn_reg;
    assign m_clusters_left    = m_left_reg;

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_found_reg |-> m_lcn_reg == '0 && m_left_reg == '0)
        else $error("miss word carries a nonzero cluster or count");

    a_hit_left: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_found_reg |-> m_left_reg != '0)
        else $error("hit word reports no clusters left");

    a_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        go && emit |=> phase_reg == PH_IDLE && m_valid_reg)
        else $error("result did not leave the unit idle with a word pending");

    a_len_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LENGTH |-> byte_pos_reg < length_bytes_reg)
        else $error("length byte position past the length field");

    a_delta_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DELTA |-> byte_pos_reg < delta_bytes_reg)
        else $error("delta byte position past the delta field");

endmodule
